// ===== rtl/srg_pkg.sv =====
package srg_pkg;

	localparam int RETIRED_DEPTH_DEF = 8;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic       MODE_PACKET = 1'b0;
	localparam logic       MODE_QUERY  = 1'b1;

	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_DECODE    = 3'd1;
	localparam logic [2:0] RC_FIRST_SEQ = 3'd2;
	localparam logic [2:0] RC_RETIRED   = 3'd3;
	localparam logic [2:0] RC_REPLAY    = 3'd4;
	localparam logic [2:0] RC_REGRESS   = 3'd5;

	localparam logic [1:0] REG_TIMEOUT    = 2'd0;
	localparam logic [1:0] REG_POSE_MASK  = 2'd1;
	localparam logic [1:0] REG_INPUT_MASK = 2'd2;

	localparam logic [63:0] TIMEOUT_RST    = 64'd100000000;
	localparam logic [15:0] POSE_MASK_RST  = 16'd15;
	localparam logic [15:0] INPUT_MASK_RST = 16'd17;

	typedef struct packed {
		logic        mode;
		logic        decode_ok;
		logic [63:0] session_id;
		logic [31:0] sequence_req;
		logic        is_heartbeat;
		logic        hand;
		logic [63:0] source_time;
		logic [63:0] time_now;
		logic [15:0] state_flags;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic        stale;
		logic        state_known;
		logic [15:0] flags_out;
		logic [63:0] hand_time_out;
		logic        pose_publishable;
		logic        input_publishable;
		logic [63:0] current_session;
	} result_t;

	typedef struct packed {
		logic [63:0] watchdog_timeout;
		logic [15:0] pose_required_mask;
		logic [15:0] input_required_mask;
	} cfg_t;

endpackage

// ===== rtl/srg_cell.sv =====
module srg_cell
	import srg_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [63:0] sid,
	input  logic        occupied,
	input  logic        shift,
	input  logic [63:0] shift_in,
	output logic [63:0] entry,
	output logic        match
);

	logic [63:0] entry_q;
	logic        match_s1;

	// compare is registered at accept; the ring only moves at commit
	always_ff @(posedge clk) begin
		if (load) begin
			match_s1 <= occupied && (entry_q == sid);
		end
		if (shift) begin
			entry_q <= shift_in;
		end
	end

	assign entry = entry_q;
	assign match = match_s1;

endmodule

// ===== rtl/srg_cfg.sv =====
module srg_cfg
	import srg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watchdog_timeout    <= TIMEOUT_RST;
			cfg_q.pose_required_mask  <= POSE_MASK_RST;
			cfg_q.input_required_mask <= INPUT_MASK_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TIMEOUT:    cfg_q.watchdog_timeout    <= pwdata;
				REG_POSE_MASK:  cfg_q.pose_required_mask  <= pwdata[15:0];
				REG_INPUT_MASK: cfg_q.input_required_mask <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TIMEOUT:    prdata = cfg_q.watchdog_timeout;
			REG_POSE_MASK:  prdata = {48'd0, cfg_q.pose_required_mask};
			REG_INPUT_MASK: prdata = {48'd0, cfg_q.input_required_mask};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/session_replay_guard_watchdog.sv =====
// Item and ring compare are registered at acceptance; checks and state update follow as
// the evaluation completes. The input stalls while an item is evaluated, so a new item
// is not taken before the last result is registered, and a stalled result holds the
// evaluation until the output register frees up.
// Reset (arst_n low, asynchronous): session state, fill count and handshakes cleared,
// registers back to timeout 100000000, pose mask 15, input mask 17; ring entries not reset.
module session_replay_guard_watchdog
	import srg_pkg::*;
#(
	parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CNT_W = $clog2(RETIRED_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	cfg_t cfg;

	logic        state_q;
	item_t       item_s1;
	logic        accept;
	logic        done;
	logic        commit;
	logic        retire;

	logic        session_valid_q;
	logic [63:0] active_q;
	logic [31:0] last_seq_q;
	logic [63:0] hb_time_q;
	logic [63:0] hand_time_q [2];
	logic [15:0] hand_flags_q [2];
	logic [1:0]  hand_seen_q;
	logic [63:0] arrival_q;
	logic [CNT_W-1:0] count_q;

	result_t     result_q;
	logic        result_valid_q;

	logic [63:0] chain [RETIRED_DEPTH+1];
	logic [RETIRED_DEPTH-1:0] match_vec;

	logic        fresh;
	logic        hit;
	logic [63:0] prior;
	logic [2:0]  rcode;
	logic [63:0] age;
	logic        stale;
	logic [15:0] flags;
	logic        seen;
	result_t     res;

	srg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_stall = (state_q == ST_EVAL);
	assign accept     = item_valid && !item_stall;
	assign done       = (state_q == ST_EVAL) && (!result_valid_q || !result_stall);

	// newest retired session enters at cell 0, oldest falls off the end
	assign chain[0] = active_q;

	for (genvar k = 0; k < RETIRED_DEPTH; k++) begin : g_cell
		srg_cell u_cell (
			.clk      (clk),
			.load     (accept),
			.sid      (item.session_id),
			.occupied (CNT_W'(k) < count_q),
			.shift    (retire),
			.shift_in (chain[k]),
			.entry    (chain[k+1]),
			.match    (match_vec[k])
		);
	end

	always_comb begin
		fresh = !session_valid_q || (item_s1.session_id != active_q);
		hit   = |match_vec;
		prior = item_s1.is_heartbeat ? hb_time_q : hand_time_q[item_s1.hand];

		if (!item_s1.decode_ok) begin
			rcode = RC_DECODE;
		end else if (fresh && (item_s1.sequence_req != 32'd0)) begin
			rcode = RC_FIRST_SEQ;
		end else if (fresh && hit) begin
			rcode = RC_RETIRED;
		end else if (!fresh && (item_s1.sequence_req <= last_seq_q)) begin
			rcode = RC_REPLAY;
		end else if (!fresh && (item_s1.source_time < prior)) begin
			rcode = RC_REGRESS;
		end else begin
			rcode = RC_OK;
		end

		age   = item_s1.time_now - arrival_q;
		stale = !session_valid_q || (item_s1.time_now < arrival_q)
			|| (age >= cfg.watchdog_timeout);
		flags = hand_flags_q[item_s1.hand];
		seen  = hand_seen_q[item_s1.hand];

		res = '0;
		if (item_s1.mode == MODE_QUERY) begin
			res.result_code = RC_OK;
			res.stale       = stale;
			res.state_known = seen;
			if (!stale) begin
				res.flags_out         = flags;
				res.hand_time_out     = hand_time_q[item_s1.hand];
				res.pose_publishable  = seen &&
					((flags & cfg.pose_required_mask) == cfg.pose_required_mask);
				res.input_publishable = seen &&
					((flags & cfg.input_required_mask) == cfg.input_required_mask);
			end
			res.current_session = active_q;
		end else begin
			res.result_code     = rcode;
			res.current_session = (rcode == RC_OK) ? item_s1.session_id : active_q;
		end
	end

	assign commit = done && (item_s1.mode == MODE_PACKET) && (rcode == RC_OK);
	assign retire = commit && fresh && session_valid_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (done) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EVAL;
				ST_EVAL: if (done)   state_q <= ST_IDLE;
				default:             state_q <= ST_IDLE;
			endcase
			if (done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_valid_q <= 1'b0;
			active_q        <= '0;
			last_seq_q      <= '0;
			hb_time_q       <= '0;
			hand_time_q[0]  <= '0;
			hand_time_q[1]  <= '0;
			hand_flags_q[0] <= '0;
			hand_flags_q[1] <= '0;
			hand_seen_q     <= '0;
			arrival_q       <= '0;
			count_q         <= '0;
		end else if (commit) begin
			if (retire && (count_q != CNT_W'(RETIRED_DEPTH))) begin
				count_q <= count_q + CNT_W'(1);
			end
			session_valid_q <= 1'b1;
			active_q        <= item_s1.session_id;
			last_seq_q      <= item_s1.sequence_req;
			arrival_q       <= item_s1.time_now;
			if (fresh) begin
				// new session: per-session state starts over, then this packet applies
				hb_time_q       <= '0;
				hand_time_q[0]  <= '0;
				hand_time_q[1]  <= '0;
				hand_flags_q[0] <= '0;
				hand_flags_q[1] <= '0;
				hand_seen_q     <= '0;
			end
			if (item_s1.is_heartbeat) begin
				hb_time_q <= item_s1.source_time;
			end else begin
				hand_time_q[item_s1.hand]  <= item_s1.source_time;
				hand_flags_q[item_s1.hand] <= item_s1.state_flags;
				hand_seen_q[item_s1.hand]  <= 1'b1;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
